// ----- src/assert_macros.svh -----
// assertion helpers for the rtl files, included by ifp_back
// both expect clk and rst_n in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ifp_pkg.sv -----
package ifp_pkg;

  // frame layout
  localparam int FRAME_BYTES  = 11;
  localparam int SAMPLE_BYTES = 6;
  localparam logic [3:0] LAST_POS   = 4'(FRAME_BYTES - 1);
  localparam logic [3:0] SAMPLE_END = 4'd7;

  localparam logic [7:0] HEAD_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // input word function codes
  localparam logic [1:0] FUNC_BYTE     = 2'd0;
  localparam logic [1:0] FUNC_LINE_ERR = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;

  // frame kinds as carried through the queue
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // result event codes
  localparam logic [2:0] EV_ACCEL  = 3'd0;
  localparam logic [2:0] EV_GYRO   = 3'd1;
  localparam logic [2:0] EV_ANGLE  = 3'd2;
  localparam logic [2:0] EV_BADSUM = 3'd3;
  localparam logic [2:0] EV_STALE  = 3'd4;

  // register indexes
  localparam logic [1:0] REG_NEGATE_MASK   = 2'd0;
  localparam logic [1:0] REG_ROLL_OFFSET   = 2'd1;
  localparam logic [1:0] REG_PITCH_OFFSET  = 2'd2;
  localparam logic [1:0] REG_STALE_TIMEOUT = 2'd3;

  // register reset values
  localparam logic [2:0]  NEGATE_MASK_RST   = 3'd3;
  localparam logic [12:0] ROLL_OFFSET_RST   = 13'h1F66;
  localparam logic [12:0] PITCH_OFFSET_RST  = 13'd117;
  localparam logic [15:0] STALE_TIMEOUT_RST = 16'd500;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    JOB_FRAME,
    JOB_BADSUM,
    JOB_TICK
  } job_kind_t;

  // work handed from the framing front to the back
  typedef struct packed {
    job_kind_t                         kind;
    logic [1:0]                        frame_kind;
    logic [SAMPLE_BYTES-1:0][7:0]      samples;
  } job_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic signed [16:0] vec_x;
    logic signed [16:0] vec_y;
    logic signed [16:0] vec_z;
    logic               data_valid;
    logic [31:0]        good_frames;
    logic [31:0]        bad_checksums;
  } result_t;

  typedef struct packed {
    logic [2:0]         negate_mask;
    logic signed [12:0] roll_offset;
    logic signed [12:0] pitch_offset;
    logic [15:0]        stale_timeout;
  } cfg_t;

endpackage

// ----- src/ifp_fifo.sv -----
module ifp_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- src/ifp_front.sv -----
module ifp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [1:0]    func,
  input  logic [7:0]    data_byte,
  output logic          full,
  output logic          job_push,
  output ifp_pkg::job_t job,
  input  logic          job_full
);

  logic [3:0] pos_r, pos_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [ifp_pkg::SAMPLE_BYTES-1:0][7:0] samples_r;
  logic       accept;
  logic       store_en;
  logic [2:0] store_idx;
  logic [7:0] sum_add;
  logic       is_type;

  assign full      = job_full;
  assign accept    = push && !job_full;
  assign sum_add   = sum_r + data_byte;
  assign store_idx = pos_r[2:0] - 3'd2;
  assign is_type   = (data_byte == ifp_pkg::TYPE_ACCEL) ||
                     (data_byte == ifp_pkg::TYPE_GYRO)  ||
                     (data_byte == ifp_pkg::TYPE_ANGLE);

  // framing: header sync, type check, payload collection, checksum; line errors and ticks
  always_comb begin
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    sum_nxt  = sum_r;
    store_en = 1'b0;
    job_push = 1'b0;
    job.kind       = ifp_pkg::JOB_TICK;
    job.frame_kind = kind_r;
    job.samples    = samples_r;
    if (accept) begin
      case (func)
        ifp_pkg::FUNC_BYTE: begin
          if (pos_r == 4'd0) begin
            if (data_byte == ifp_pkg::HEAD_BYTE) begin
              pos_nxt = 4'd1;
              sum_nxt = data_byte;
            end
          end else if (pos_r == 4'd1) begin
            if (is_type) begin
              kind_nxt = data_byte[1:0] - ifp_pkg::TYPE_ACCEL[1:0];
              sum_nxt  = sum_add;
              pos_nxt  = 4'd2;
            end else if (data_byte == ifp_pkg::HEAD_BYTE) begin
              pos_nxt = 4'd1;
              sum_nxt = data_byte;
            end else begin
              pos_nxt = 4'd0;
            end
          end else if (pos_r >= ifp_pkg::LAST_POS) begin
            // checksum byte closes the frame
            pos_nxt  = 4'd0;
            job_push = 1'b1;
            job.kind = (sum_r == data_byte) ? ifp_pkg::JOB_FRAME : ifp_pkg::JOB_BADSUM;
          end else begin
            store_en = (pos_r <= ifp_pkg::SAMPLE_END);
            sum_nxt  = sum_add;
            pos_nxt  = pos_r + 4'd1;
          end
        end
        ifp_pkg::FUNC_LINE_ERR: begin
          pos_nxt = 4'd0;
        end
        ifp_pkg::FUNC_TICK: begin
          job_push = 1'b1;
          job.kind = ifp_pkg::JOB_TICK;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      kind_r <= '0;
      sum_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // sample bytes of the frame in progress
  always_ff @(posedge clk) begin
    if (store_en) begin
      samples_r[store_idx] <= data_byte;
    end
  end

endmodule

// ----- src/ifp_back.sv -----
`include "assert_macros.svh"

module ifp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ifp_pkg::cfg_t    cfg,
  input  logic             job_empty,
  input  ifp_pkg::job_t    job,
  output logic             job_pop,
  output logic             res_push,
  output ifp_pkg::result_t res,
  input  logic             res_full
);

  logic        valid_r, valid_nxt;
  logic        seen_gyro_r, seen_gyro_nxt;
  logic        seen_angle_r, seen_angle_nxt;
  logic        seen_update_r, seen_update_nxt;
  logic [15:0] age_r, age_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;
  logic [15:0] age_inc;
  logic        is_angle;
  logic signed [16:0] vx, vy, vz;

  // sign-extend, optional negate, optional offset subtract
  function automatic logic signed [16:0] axis_value(
    input logic [15:0]        raw,
    input logic               neg,
    input logic signed [12:0] off,
    input logic               use_off
  );
    logic signed [16:0] v;
    logic signed [16:0] o;
    v = 17'(signed'(raw));
    o = use_off ? 17'(off) : 17'sd0;
    if (neg) begin
      v = -v;
    end
    return v - o;
  endfunction

  assign job_pop  = !job_empty && !res_full;
  assign is_angle = (job.frame_kind == ifp_pkg::KIND_ANGLE);
  assign age_inc  = (age_r != ifp_pkg::AGE_MAX) ? age_r + 16'd1 : age_r;

  // vector datapath
  assign vx = axis_value({job.samples[1], job.samples[0]}, cfg.negate_mask[0],
                         cfg.roll_offset, is_angle);
  assign vy = axis_value({job.samples[3], job.samples[2]}, cfg.negate_mask[1],
                         cfg.pitch_offset, is_angle);
  assign vz = axis_value({job.samples[5], job.samples[4]}, cfg.negate_mask[2],
                         13'sd0, 1'b0);

  // state update and result assembly
  always_comb begin
    valid_nxt       = valid_r;
    seen_gyro_nxt   = seen_gyro_r;
    seen_angle_nxt  = seen_angle_r;
    seen_update_nxt = seen_update_r;
    age_nxt         = age_r;
    good_nxt        = good_r;
    bad_nxt         = bad_r;
    res_push        = 1'b0;
    res.event_res   = ifp_pkg::EV_BADSUM;
    res.vec_x       = '0;
    res.vec_y       = '0;
    res.vec_z       = '0;
    if (job_pop) begin
      case (job.kind)
        ifp_pkg::JOB_FRAME: begin
          if (job.frame_kind == ifp_pkg::KIND_ANGLE) begin
            seen_angle_nxt = 1'b1;
          end else if (job.frame_kind == ifp_pkg::KIND_GYRO) begin
            seen_gyro_nxt = 1'b1;
          end
          good_nxt        = good_r + 32'd1;
          valid_nxt       = seen_gyro_nxt || seen_angle_nxt;
          seen_update_nxt = 1'b1;
          age_nxt         = '0;
          res_push        = 1'b1;
          res.event_res   = {1'b0, job.frame_kind};
          res.vec_x       = vx;
          res.vec_y       = vy;
          res.vec_z       = vz;
        end
        ifp_pkg::JOB_BADSUM: begin
          bad_nxt       = bad_r + 32'd1;
          res_push      = 1'b1;
          res.event_res = ifp_pkg::EV_BADSUM;
        end
        ifp_pkg::JOB_TICK: begin
          if (seen_update_r) begin
            age_nxt = age_inc;
            if (valid_r && (age_inc > cfg.stale_timeout)) begin
              valid_nxt     = 1'b0;
              res_push      = 1'b1;
              res.event_res = ifp_pkg::EV_STALE;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.data_valid    = valid_nxt;
    res.good_frames   = good_nxt;
    res.bad_checksums = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= 1'b0;
      seen_gyro_r   <= 1'b0;
      seen_angle_r  <= 1'b0;
      seen_update_r <= 1'b0;
      age_r         <= '0;
      good_r        <= '0;
      bad_r         <= '0;
    end else begin
      valid_r       <= valid_nxt;
      seen_gyro_r   <= seen_gyro_nxt;
      seen_angle_r  <= seen_angle_nxt;
      seen_update_r <= seen_update_nxt;
      age_r         <= age_nxt;
      good_r        <= good_nxt;
      bad_r         <= bad_nxt;
    end
  end

  // checks
  `ASSERT_IMPLIES(a_valid_needs_seen, valid_r, seen_update_r && (seen_gyro_r || seen_angle_r), "valid without a seen gyro or angle frame")
  `ASSERT_NEXT(a_stale_clears_valid, res_push && (res.event_res == ifp_pkg::EV_STALE), !valid_r, "stale event left valid set")
  `ASSERT_NEXT(a_frame_resets_age, job_pop && (job.kind == ifp_pkg::JOB_FRAME), (age_r == 16'd0) && (good_r == $past(good_r) + 32'd1), "good frame did not restart age or count")
  `ASSERT_IMPLIES(a_push_needs_pop, res_push, job_pop && !res_full, "result pushed without a job")

endmodule

// ----- src/imu_frame_parser.sv -----
// imu_frame_parser: framing and decode of a serial inertial sensor stream
//
// input queue: one word per accepted push (push high, full low) carries func
// and data_byte: a received byte, a line error that restarts framing, or a
// millisecond tick. result queue: while empty is low the oldest result is on
// the out_ ports and pop takes it. a result comes from the checksum byte of a
// frame (good or bad) and from the tick on which the data goes stale.
// apb port: four registers at byte addresses 0, 4, 8, 12, written in the
// access phase, pready tied high, reads return the stored value.
// a checksum byte or a tick becomes a job in the job queue, and the back writes
// any result into the output queue. throughput: one word per cycle while full
// is low, set by the combinational framing step and the one-job-per-cycle back.
// a job queue of JOB_DEPTH words sits between front and back and an output
// queue of OUT_DEPTH results after the back; when pop stays low these fill
// and full rises, so no word is lost.
// reset (rst_n low, synchronous) drops any frame in progress, clears flags,
// age and counters, empties both queues and loads register defaults.
module imu_frame_parser #(
  parameter int JOB_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_data_byte,
  // results
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_event_res,
  output logic signed [16:0] out_vec_x,
  output logic signed [16:0] out_vec_y,
  output logic signed [16:0] out_vec_z,
  output logic               out_data_valid,
  output logic [31:0]        out_good_frames,
  output logic [31:0]        out_bad_checksums,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  ifp_pkg::cfg_t    cfg_r, cfg_nxt;
  ifp_pkg::job_t    job_in, job_out;
  ifp_pkg::result_t res_in, res_out;
  logic             job_push, job_full, job_pop, job_empty;
  logic             res_push, res_full;
  logic [1:0]       reg_idx;
  logic             reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      case (reg_idx)
        ifp_pkg::REG_NEGATE_MASK:   cfg_nxt.negate_mask   = pwdata[2:0];
        ifp_pkg::REG_ROLL_OFFSET:   cfg_nxt.roll_offset   = pwdata[12:0];
        ifp_pkg::REG_PITCH_OFFSET:  cfg_nxt.pitch_offset  = pwdata[12:0];
        ifp_pkg::REG_STALE_TIMEOUT: cfg_nxt.stale_timeout = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.negate_mask   <= ifp_pkg::NEGATE_MASK_RST;
      cfg_r.roll_offset   <= ifp_pkg::ROLL_OFFSET_RST;
      cfg_r.pitch_offset  <= ifp_pkg::PITCH_OFFSET_RST;
      cfg_r.stale_timeout <= ifp_pkg::STALE_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      ifp_pkg::REG_NEGATE_MASK:   prdata = {29'd0, cfg_r.negate_mask};
      ifp_pkg::REG_ROLL_OFFSET:   prdata = {19'd0, cfg_r.roll_offset};
      ifp_pkg::REG_PITCH_OFFSET:  prdata = {19'd0, cfg_r.pitch_offset};
      ifp_pkg::REG_STALE_TIMEOUT: prdata = {16'd0, cfg_r.stale_timeout};
      default:                    prdata = '0;
    endcase
  end

  // framing front
  ifp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .func      (in_func),
    .data_byte (in_data_byte),
    .full      (full),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  // job queue between front and back
  ifp_fifo #(
    .DATA_W ($bits(ifp_pkg::job_t)),
    .DEPTH  (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  // decode and status back
  ifp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // output queue
  ifp_fifo #(
    .DATA_W ($bits(ifp_pkg::result_t)),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_event_res     = res_out.event_res;
  assign out_vec_x         = res_out.vec_x;
  assign out_vec_y         = res_out.vec_y;
  assign out_vec_z         = res_out.vec_z;
  assign out_data_valid    = res_out.data_valid;
  assign out_good_frames   = res_out.good_frames;
  assign out_bad_checksums = res_out.bad_checksums;

endmodule
